### hw/rtl/mi_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths, datapath operation codes and the controller status bundle.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int MW = 31;       // modulus and inverse width
	localparam int SW = MW + 2;   // signed Bezout coefficient width

	typedef logic [3:0] op_t;

	localparam op_t OP_IDLE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_RED   = 4'd2;
	localparam op_t OP_INIT  = 4'd3;
	localparam op_t OP_START = 4'd4;
	localparam op_t OP_ALIGN = 4'd5;
	localparam op_t OP_DIV   = 4'd6;
	localparam op_t OP_UPD   = 4'd7;
	localparam op_t OP_DONE  = 4'd8;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_last;
		logic can_double;
		logic cr_zero;
		logic mod_small;
	} mi_status_t;

endpackage

### hw/rtl/mi_ctrl.sv
// ----------------------------------------------------------------------------
// Modular inverse controller
// Sequences reduction, shift-subtract division steps and result hand-off.
// ----------------------------------------------------------------------------
module mi_ctrl
	import mi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  mi_status_t status,
	output op_t        op
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RED   = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_TEST  = 3'd3;
	localparam logic [2:0] ST_ALIGN = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_UPD   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		op       = OP_IDLE;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op       = OP_LOAD;
					state_nx = status.mod_small ? ST_FIN : ST_RED;
				end
			end
			ST_RED: begin
				op = OP_RED;
				if (status.cnt_last) begin
					state_nx = ST_INIT;
				end
			end
			ST_INIT: begin
				op       = OP_INIT;
				state_nx = ST_TEST;
			end
			ST_TEST: begin
				if (status.cr_zero) begin
					state_nx = ST_FIN;
				end else begin
					op       = OP_START;
					state_nx = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (status.can_double) begin
					op = OP_ALIGN;
				end else begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				op = OP_DIV;
				if (status.cnt_zero) begin
					state_nx = ST_UPD;
				end
			end
			ST_UPD: begin
				op       = OP_UPD;
				state_nx = ST_TEST;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					op       = OP_DONE;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (op == OP_DONE) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside finish state");
`endif

endmodule

### hw/rtl/mi_datapath.sv
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Input reduction, extended Euclid registers, shift-subtract divider and
// result register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module mi_datapath
	import mi_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  logic [WIDTH-1:0] value,
	input  logic             cfg_we,
	input  logic [MW-1:0]    cfg_wdata,
	output mi_status_t       status,
	output logic [MW-1:0]    inverse,
	output logic             has_inverse
);

	localparam int CMAX = (WIDTH > MW) ? WIDTH : MW;
	localparam int CW   = $clog2(CMAX + 1);

	logic [MW-1:0]        mod_q;
	logic [WIDTH-1:0]     mag_q;
	logic                 neg_q;
	logic [MW-1:0]        rem_q;
	logic [MW-1:0]        or_q;
	logic [MW-1:0]        cr_q;
	logic [MW-1:0]        d_q;
	logic signed [SW-1:0] os_q;
	logic signed [SW-1:0] cs_q;
	logic signed [SW-1:0] prod_q;
	logic [CW-1:0]        cnt_q;
	logic [MW-1:0]        inv_q;
	logic                 has_q;

	logic                 in_neg;
	logic [WIDTH-1:0]     in_mag;
	logic [MW:0]          red_t;
	logic [MW:0]          red_nx;
	logic [MW-1:0]        fix;
	logic                 div_ge;
	logic signed [SW-1:0] prod_nx;
	logic signed [SW-1:0] norm;

	assign in_neg = value[WIDTH-1];
	assign in_mag = in_neg ? (~value + 1'b1) : value;

	assign red_t  = {rem_q, mag_q[WIDTH-1]};
	assign red_nx = (red_t >= {1'b0, mod_q}) ? (red_t - {1'b0, mod_q}) : red_t;
	assign fix    = (neg_q && (rem_q != '0)) ? (mod_q - rem_q) : rem_q;

	assign div_ge  = (rem_q >= d_q);
	assign prod_nx = {prod_q[SW-2:0], 1'b0} + (div_ge ? cs_q : '0);
	assign norm    = os_q[SW-1] ? (os_q + $signed({2'b00, mod_q})) : os_q;

	assign status.cnt_zero   = (cnt_q == '0);
	assign status.cnt_last   = (cnt_q == CW'(1));
	assign status.can_double = (d_q <= (or_q >> 1));
	assign status.cr_zero    = (cr_q == '0);
	assign status.mod_small  = (mod_q < MW'(2));

	assign inverse     = inv_q;
	assign has_inverse = has_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MW'(2);
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				mag_q <= in_mag;
				neg_q <= in_neg;
				rem_q <= '0;
				cnt_q <= CW'(WIDTH);
				or_q  <= '0;
				os_q  <= '0;
			end
			OP_RED: begin
				rem_q <= red_nx[MW-1:0];
				mag_q <= {mag_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_INIT: begin
				or_q <= fix;
				cr_q <= mod_q;
				os_q <= SW'(1);
				cs_q <= '0;
			end
			OP_START: begin
				d_q    <= cr_q;
				rem_q  <= or_q;
				cnt_q  <= '0;
				prod_q <= '0;
			end
			OP_ALIGN: begin
				d_q   <= {d_q[MW-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - d_q;
				end
				prod_q <= prod_nx;
				d_q    <= d_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			OP_UPD: begin
				or_q <= cr_q;
				cr_q <= rem_q;
				os_q <= cs_q;
				cs_q <= os_q - prod_q;
			end
			OP_DONE: begin
				inv_q <= (or_q == MW'(1)) ? norm[MW-1:0] : '0;
				has_q <= (or_q == MW'(1));
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_red_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_RED) |-> (rem_q < mod_q))
		else $error("reduction remainder not below modulus");

	a_align_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_ALIGN) |-> !d_q[MW-1])
		else $error("divisor alignment overflow");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_UPD) |-> (rem_q < cr_q))
		else $error("division remainder not below divisor");
`endif

endmodule

### hw/rtl/modular_inverse_core.sv
// ----------------------------------------------------------------------------
// Modular inverse core
// Inverse of a signed value modulo a programmable modulus by extended Euclid.
// ----------------------------------------------------------------------------
// One item is processed at a time. Each item loads and reduces the input into
// 0 to modulus-1 (one restoring step per input bit), then runs Euclid steps,
// each of which tests the remainder, aligns the divisor, divides and updates
// the coefficients, and finally detects the end and loads the result. The
// single shift-subtract divider works one quotient bit per cycle.
// A new beat is taken as soon as the previous result is registered, even
// while that result still waits on m_tready. A modulus below 2 yields
// inverse 0 with has_inverse low.
// ----------------------------------------------------------------------------
module modular_inverse_core
	import mi_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [MW-1:0]                   cfg_wdata,  // modulus
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [((WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [WIDTH-1:0] value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,    // [30:0] inverse
	output logic                            m_tuser     // [0] has_inverse
);

	op_t           op;
	mi_status_t    status;
	logic [MW-1:0] inverse;

	mi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	mi_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.value       (s_tdata[WIDTH-1:0]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.status      (status),
		.inverse     (inverse),
		.has_inverse (m_tuser)
	);

	assign m_tdata = {1'b0, inverse};

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Modular inverse core testbench
// Streams signed values through the core and checks each inverse and its
// has_inverse flag against an extended Euclid predictor. The modulus is
// reprogrammed between phases. The phases cover both ends of the modulus
// range, moduli below two, composite moduli and prime moduli. Both sides of
// the stream idle at several rates.
// ----------------------------------------------------------------------------
module tb_top;
	import mi_pkg::*;

	localparam int  VW          = 32;
	localparam int  CYCLE_LIMIT = 4_000_000;
	localparam int  DRAIN_WAIT  = VW + 300;

	typedef struct {
		logic [MW-1:0] inverse;
		logic          has_inverse;
	} inv_pair_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_we    = 1'b0;
	logic [MW-1:0] cfg_wdata = '0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	logic [VW-1:0] s_tdata   = '0;  // [31:0] value
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	logic [31:0]   m_tdata;         // [30:0] inverse
	logic          m_tuser;         // [0] has_inverse

	inv_pair_t     pending_inverses[$];
	logic [MW-1:0] modulus_cfg    = MW'(2);
	int            src_idle_pct   = 0;
	int            sink_stall_pct = 0;
	int            mismatch_count = 0;
	int            cycle_count    = 0;

	modular_inverse_core #(
		.WIDTH(VW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic inv_pair_t mod_inverse(input logic [MW-1:0] m, input logic [VW-1:0] v);
		longint    mm;
		longint    r_old;
		longint    r_cur;
		longint    s_old;
		longint    s_cur;
		longint    q;
		longint    t;
		inv_pair_t res;
		res.inverse     = '0;
		res.has_inverse = 1'b0;
		mm = longint'(m);
		if (mm < 2)
			return res;
		r_old = longint'($signed(v)) % mm;
		if (r_old < 0)
			r_old = r_old + mm;
		r_cur = mm;
		s_old = 1;
		s_cur = 0;
		for (int i = 0; i < 64 && r_cur != 0; i++) begin
			q     = r_old / r_cur;
			t     = r_old - q * r_cur;
			r_old = r_cur;
			r_cur = t;
			t     = s_old - q * s_cur;
			s_old = s_cur;
			s_cur = t;
		end
		if (r_old == 1) begin
			t = s_old % mm;
			if (t < 0)
				t = t + mm;
			res.inverse     = t[MW-1:0];
			res.has_inverse = 1'b1;
		end
		return res;
	endfunction

	function automatic logic [MW-1:0] pick_modulus();
		logic [MW-1:0] m;
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(4))
					0: m = MW'(1000000007);
					1: m = MW'(65521);
					2: m = MW'(251);
					3: m = MW'(7);
					default: m = MW'(2147483629);
				endcase
			end
			1: m = MW'($urandom_range(1000, 2));
			2: m = MW'($urandom_range(32'h7FFF_FFFF, 2));
			3: m = {MW{1'b1}};
			4: m = {1'b1, (MW-1)'($urandom)};
			default: m = MW'($urandom_range(3, 2));
		endcase
		return m;
	endfunction

	function automatic logic [VW-1:0] pick_value(input logic [MW-1:0] m);
		longint unsigned kmax;
		longint          prod;
		logic [VW-1:0]   v;
		case ($urandom_range(7))
			1: v = VW'($urandom_range(2000) - 1000);
			2: begin
				kmax = 64'd2147483647 / longint'(m);
				prod = longint'($urandom_range(kmax[31:0])) * longint'(m);
				if ($urandom_range(1))
					prod = -prod;
				v = prod[VW-1:0];
			end
			3: begin
				case ($urandom_range(3))
					0: v = VW'(m) - 1;
					1: v = VW'(m) + 1;
					2: v = -(VW'(m) - 1);
					default: v = -(VW'(m) + 1);
				endcase
			end
			4: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'h0000_0001;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = VW'($urandom);
		endcase
		return v;
	endfunction

	// result checker and sink back-pressure
	always @(posedge clk) begin
		inv_pair_t exp_pair;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_inverses.size() == 0) begin
					$error("unexpected result beat: inverse %0d, has_inverse %0b",
						m_tdata[MW-1:0], m_tuser);
					mismatch_count++;
				end else begin
					exp_pair = pending_inverses.pop_front();
					if (m_tdata[MW-1:0] !== exp_pair.inverse) begin
						$error("inverse mismatch: expected %0d, actual %0d",
							exp_pair.inverse, m_tdata[MW-1:0]);
						mismatch_count++;
					end
					if (m_tuser !== exp_pair.has_inverse) begin
						$error("has_inverse mismatch: expected %0b, actual %0b",
							exp_pair.has_inverse, m_tuser);
						mismatch_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** modular_inverse_core: FAILED **");
		$finish;
	end

	task automatic send_value(input logic [VW-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do
			@(posedge clk);
		while (!s_tready);
		pending_inverses.push_back(mod_inverse(modulus_cfg, v));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [MW-1:0] m);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		modulus_cfg = m;
	endtask

	task automatic test_reset_modulus();
		send_value(32'h0000_0000);
		send_value(32'h0000_0001);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		wait_drained();
	endtask

	task automatic test_special_cases();
		write_modulus({MW{1'b1}});
		send_value(32'h0000_0000);
		send_value(32'h0000_0001);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h8000_0001);
		send_value(32'h0000_0002);
		send_value(32'h5555_5555);
		send_value(32'hAAAA_AAAA);
		write_modulus(MW'(12));
		send_value(32'd5);
		send_value(32'd6);
		send_value(-32'sd7);
		send_value(32'd0);
		write_modulus('0);
		send_value(32'd7);
		send_value(-32'sd3);
		write_modulus(MW'(1));
		send_value(32'd5);
		write_modulus(MW'(3));
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		write_modulus(MW'(1000000007));
		repeat (6)
			send_value(pick_value(modulus_cfg));
		wait_drained();
		repeat (6)
			send_value(pick_value(modulus_cfg));
		wait_drained();
	endtask

	task automatic test_random_phase(input int src_pct, input int sink_pct, input int n_items);
		int sent;
		sent           = 0;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		while (sent < n_items) begin
			write_modulus(pick_modulus());
			repeat (50) begin
				send_value(pick_value(modulus_cfg));
				sent++;
			end
		end
		wait_drained();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_modulus();
		test_special_cases();
		test_drain_pause();
		test_random_phase(0, 0, 500);
		test_random_phase(74, 0, 500);
		test_random_phase(0, 74, 500);
		test_random_phase(9, 9, 500);
		wait_drained();
		repeat (DRAIN_WAIT)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("** modular_inverse_core: PASSED **");
		else
			$display("** modular_inverse_core: FAILED **");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mi_pkg.sv
hw/rtl/mi_ctrl.sv
hw/rtl/mi_datapath.sv
hw/rtl/modular_inverse_core.sv
tb/sv/tb_top.sv
